// File: hw/rtl/clru_page_replacer_core_assert.svh
// Assertion macros shared by the page replacer RTL.
// Included by the modules that carry concurrent checks.
`ifndef CLRU_PAGE_REPLACER_CORE_ASSERT_SVH
`define CLRU_PAGE_REPLACER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CLRU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication checked on every clock edge, reset included.
`define CLRU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: hw/rtl/clru_pkg.sv
// Shared types and constants for the page replacer.
// No dependencies.
package clru_pkg;
    localparam int RESIDENT_MAX_DEF = 32;
    localparam int PAGE_W           = 12;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        FUNC_MAP    = 2'd0,
        FUNC_ACCESS = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_EVICT  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_OK      = 3'd0,
        KIND_DEMOTED = 3'd1,
        KIND_VICTIM  = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_EMPTY   = 3'd4
    } kind_t;

    // Classified command passed from front to back.
    typedef struct packed {
        func_t             func;
        logic [PAGE_W-1:0] page;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_APPEND,
        ST_EVICT,
        ST_DONE
    } state_t;
endpackage

// File: hw/rtl/clru_front.sv
// Input stage and command queue of the page replacer.
// Depends on clru_pkg.
module clru_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,
    output logic                        q_valid,
    input  logic                        q_ready,
    output clru_pkg::cmd_t              q_cmd
);
    import clru_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t               fifo_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [PTR_W:0]     cnt_reg, cnt_next;
    logic               push, pop;
    cmd_t               in_cmd;

    // Split the beat into function and page.
    always_comb begin
        in_cmd.func = func_t'(s_tdata[1:0]);
        in_cmd.page = s_tdata[2 +: PAGE_W];
    end

    assign s_tready = (cnt_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = fifo_reg[rptr_reg];
    assign cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);

    // Store the payload.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wptr_reg] <= in_cmd;
        end
    end

    // Advance pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `include "clru_page_replacer_core_assert.svh"
    `CLRU_ASSERT(a_no_overflow, aclk, aresetn, cnt_reg <= (PTR_W+1)'(QUEUE_DEPTH), "queue overflow")
    `CLRU_ASSERT(a_pop_nonempty, aclk, aresetn, pop |-> cnt_reg != '0, "pop from empty queue")
    `CLRU_ASSERT(a_count_track, aclk, aresetn, (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1, "count did not advance")
endmodule

// File: hw/rtl/clru_back.sv
// List store and command sequencer of the page replacer.
// Depends on clru_pkg.
module clru_back #(
    parameter int RESIDENT_MAX = clru_pkg::RESIDENT_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  clru_pkg::cmd_t              q_cmd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast
);
    import clru_pkg::*;

    localparam int IDX_W = $clog2(RESIDENT_MAX);
    localparam int CNT_W = $clog2(RESIDENT_MAX + 1);

    // List slots as a circular buffer, per slot mark bit.
    logic [PAGE_W-1:0]       pages_reg [RESIDENT_MAX];
    logic [RESIDENT_MAX-1:0] mark_reg, mark_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    // Demoted pages of the current tick, re-appended after the pass.
    logic [PAGE_W-1:0]       moved_pg_reg [RESIDENT_MAX];
    logic [CNT_W-1:0]        moved_cnt_reg, moved_cnt_next;
    logic                    mv_wr;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     walk_reg, walk_next;     // entries left in pass, then append index
    logic [PAGE_W-1:0]    rd_reg;                  // registered memory read

    // Output register.
    logic                 ov_reg, ov_next;
    kind_t                okind_reg, okind_next;
    logic [PAGE_W-1:0]    opage_reg, opage_next;
    logic                 olast_reg, olast_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [PAGE_W-1:0]    wr_data;
    logic                 out_free;
    logic                 last_mark;               // head holds the only mark left

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] v);
        logic [IDX_W:0] r;
        r = v;
        if (r >= (IDX_W+1)'(RESIDENT_MAX)) r = r - (IDX_W+1)'(RESIDENT_MAX);
        return r[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] head_inc;
    assign tail_idx  = wrap({1'b0, head_reg} + (IDX_W+1)'(count_reg));
    assign head_inc  = wrap({1'b0, head_reg} + (IDX_W+1)'(1));
    assign out_free  = !ov_reg || m_tready;
    assign last_mark = (mark_reg & ~(RESIDENT_MAX'(1) << head_reg)) == '0;

    // Memory: one write, one registered read; side store for demoted pages.
    always_ff @(posedge aclk) begin
        if (wr_en) pages_reg[wr_addr] <= wr_data;
        rd_reg <= pages_reg[rd_addr];
        if (mv_wr) moved_pg_reg[moved_cnt_reg[IDX_W-1:0]] <= pages_reg[head_reg];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    if (q_cmd.func == FUNC_TICK && count_reg != '0) state_next = ST_TICK;
                    else if (q_cmd.func == FUNC_EVICT && count_reg != '0)
                        state_next = ST_EVICT;
                end
            end
            ST_TICK: begin
                if (out_free && walk_reg == CNT_W'(1)) begin
                    if (moved_cnt_reg != '0 || mark_reg[head_reg]) state_next = ST_APPEND;
                    else state_next = ST_DONE;
                end
            end
            ST_APPEND: if (walk_reg + CNT_W'(1) == moved_cnt_reg) state_next = ST_IDLE;
            ST_EVICT:  if (out_free) state_next = ST_IDLE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        q_ready        = 1'b0;
        mark_next      = mark_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        moved_cnt_next = moved_cnt_reg;
        mv_wr          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = tail_idx;
        wr_data        = q_cmd.page;
        rd_addr        = head_reg;
        ov_next        = ov_reg && !m_tready;
        okind_next     = okind_reg;
        opage_next     = opage_reg;
        olast_next     = olast_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready = 1'b1;
                    unique case (q_cmd.func)
                        FUNC_MAP: begin
                            ov_next = 1'b1; olast_next = 1'b1; opage_next = '0;
                            if (count_reg == CNT_W'(RESIDENT_MAX)) begin
                                okind_next = KIND_FULL;
                            end else begin
                                okind_next = KIND_OK;
                                wr_en = 1'b1;
                                mark_next[tail_idx] = 1'b0;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_ACCESS: begin
                            // Compare the page against every slot in parallel.
                            for (int i = 0; i < RESIDENT_MAX; i++) begin
                                if (pages_reg[i] == q_cmd.page &&
                                    ((wrap((IDX_W+1)'(i) + (IDX_W+1)'(RESIDENT_MAX)
                                           - {1'b0, head_reg}) < IDX_W'(count_reg))
                                     || (count_reg == CNT_W'(RESIDENT_MAX))))
                                    mark_next[i] = 1'b1;
                            end
                            ov_next = 1'b1; olast_next = 1'b1;
                            okind_next = KIND_OK; opage_next = '0;
                        end
                        FUNC_TICK: begin
                            if (count_reg == '0) begin
                                ov_next = 1'b1; olast_next = 1'b1;
                                okind_next = KIND_OK; opage_next = '0;
                            end
                            walk_next      = count_reg;
                            moved_cnt_next = '0;
                        end
                        FUNC_EVICT: begin
                            if (count_reg == '0) begin
                                ov_next = 1'b1; olast_next = 1'b1;
                                okind_next = KIND_EMPTY; opage_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    ov_next = 1'b1; olast_next = 1'b1;
                    okind_next = KIND_VICTIM; opage_next = rd_reg;
                    mark_next[head_reg] = 1'b0;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            ST_TICK: begin
                // Visit the head entry: unmarked ones rotate to the tail (same
                // slot when full), marked ones leave the list and are reported.
                if (out_free) begin
                    head_next = head_inc;
                    walk_next = walk_reg - CNT_W'(1);
                    mark_next[head_reg] = 1'b0;
                    if (mark_reg[head_reg]) begin
                        mv_wr          = 1'b1;
                        moved_cnt_next = moved_cnt_reg + CNT_W'(1);
                        count_next     = count_reg - CNT_W'(1);
                        ov_next = 1'b1; olast_next = last_mark;
                        okind_next = KIND_DEMOTED;
                        opage_next = pages_reg[head_reg];
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = tail_idx;
                        wr_data = pages_reg[head_reg];
                        mark_next[tail_idx] = 1'b0;
                    end
                end
            end
            ST_APPEND: begin
                // Re-append demoted pages behind the kept ones, in pass order.
                wr_en      = 1'b1;
                wr_addr    = tail_idx;
                wr_data    = moved_pg_reg[walk_reg[IDX_W-1:0]];
                mark_next[tail_idx] = 1'b0;
                count_next = count_reg + CNT_W'(1);
                walk_next  = walk_reg + CNT_W'(1);
            end
            ST_DONE: begin
                // Nothing was demoted: answer with a single ok beat.
                if (out_free) begin
                    ov_next = 1'b1; olast_next = 1'b1;
                    okind_next = KIND_OK; opage_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mark_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            moved_cnt_reg <= '0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mark_reg      <= mark_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            moved_cnt_reg <= moved_cnt_next;
            ov_reg        <= ov_next;
        end
        okind_reg <= okind_next;
        opage_reg <= opage_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    always_comb begin
        m_tdata = '0;
        m_tdata[2:0] = okind_reg;
        m_tdata[3 +: PAGE_W] = opage_reg;
    end

    `include "clru_page_replacer_core_assert.svh"
    `CLRU_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(RESIDENT_MAX), "count over max")
    `CLRU_ASSERT(a_hold_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
    `CLRU_ASSERT(a_idle_pop, aclk, aresetn, q_ready |-> state_reg == ST_IDLE, "pop outside idle")
endmodule

// File: hw/rtl/clru_page_replacer_core.sv
// Approximate-LRU page replacer: top level.
// Depends on clru_pkg, clru_front, clru_back.
//
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata: func in bits [1:0],
//   page_number in bits [13:2]. Results on m_tvalid/m_tready/m_tdata with
//   result_kind in [2:0], result_page in [14:3], m_tlast on the final
//   result of each input item.
//   A two-entry command queue decouples input from the sequencer, so input
//   is taken while a result waits on the output register.
//   Map, access and an evict on an empty list are answered from the idle
//   state; an evict with a resident page goes through the evict state for
//   the registered memory read. A tick visits one entry per cycle while the
//   output register is free, then re-appends each demoted page behind the
//   kept ones, one per cycle; when nothing is demoted it ends in the done
//   state, which sends the single ok beat.
//   Reset (aresetn low, synchronous) empties the list and clears all marks.
//   When m_tready is low the sequencer holds and the queue fills, then
//   s_tready drops.
module clru_page_replacer_core #(
    parameter int RESIDENT_MAX = clru_pkg::RESIDENT_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // func[1:0], page_number[13:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // result_kind[2:0], result_page[14:3]
    output logic        m_tlast
);
    import clru_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;

    clru_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    clru_back #(.RESIDENT_MAX(RESIDENT_MAX)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );
endmodule

// File: tb/sv/clru_page_replacer_core_tb.sv
// Self-checking testbench for the approximate-LRU page replacer core.
// Depends on clru_pkg and clru_page_replacer_core; drives input beats and
// checks every result beat against a behavioral list model.
module clru_page_replacer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import clru_pkg::*;

    localparam int NPAGE = RESIDENT_MAX_DEF;

    typedef struct packed {
        kind_t             kind;
        logic [PAGE_W-1:0] page;
        logic              last;
    } res_t;

    typedef struct {
        func_t             func;
        logic [PAGE_W-1:0] page;
        bit                fixed;   // expected result typed in below
        kind_t             kind;
        logic [PAGE_W-1:0] rpage;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    clru_page_replacer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model state of the resident list
    logic [PAGE_W-1:0] lst_page [NPAGE];
    bit                lst_mark [NPAGE];
    int                lst_cnt = 0;

    res_t pending_res[$];
    int   errors = 0;
    int   n_results = 0;
    int   n_demoted = 0;
    int   n_victims = 0;
    int   n_full = 0;
    int   n_empty = 0;

    function automatic void push_res(kind_t k, logic [PAGE_W-1:0] p);
        res_t r;
        r.kind = k; r.page = p; r.last = 1'b0;
        pending_res.push_back(r);
    endfunction

    // Compute the results of one beat and advance the list model
    function automatic void predict_list(func_t f, logic [PAGE_W-1:0] p);
        logic [PAGE_W-1:0] kept [NPAGE];
        logic [PAGE_W-1:0] moved [NPAGE];
        int nk, nm;
        nk = 0; nm = 0;
        case (f)
            FUNC_MAP: begin
                if (lst_cnt >= NPAGE) push_res(KIND_FULL, '0);
                else begin
                    lst_page[lst_cnt] = p; lst_mark[lst_cnt] = 0;
                    lst_cnt++;
                    push_res(KIND_OK, '0);
                end
            end
            FUNC_ACCESS: begin
                for (int i = 0; i < lst_cnt; i++)
                    if (lst_page[i] == p) lst_mark[i] = 1;
                push_res(KIND_OK, '0);
            end
            FUNC_TICK: begin
                for (int i = 0; i < lst_cnt; i++) begin
                    if (lst_mark[i]) begin
                        moved[nm++] = lst_page[i];
                        push_res(KIND_DEMOTED, lst_page[i]);
                    end else kept[nk++] = lst_page[i];
                end
                for (int i = 0; i < nk; i++) lst_page[i] = kept[i];
                for (int i = 0; i < nm; i++) lst_page[nk + i] = moved[i];
                for (int i = 0; i < lst_cnt; i++) lst_mark[i] = 0;
                if (nm == 0) push_res(KIND_OK, '0);
            end
            default: begin
                if (lst_cnt == 0) push_res(KIND_EMPTY, '0);
                else begin
                    push_res(KIND_VICTIM, lst_page[0]);
                    for (int i = 1; i < lst_cnt; i++) begin
                        lst_page[i-1] = lst_page[i];
                        lst_mark[i-1] = lst_mark[i];
                    end
                    lst_cnt--;
                end
            end
        endcase
        pending_res[$].last = 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drop valid only for an idle gap so back-to-back beats keep it high
    task automatic send_beat(func_t f, logic [PAGE_W-1:0] p);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, p, f};
        predict_list(f, p);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random page from a small pool so that accesses hit resident entries
    function automatic logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 9) < 7) begin
            if (lst_cnt > 0 && $urandom_range(0, 1))
                return lst_page[$urandom_range(0, lst_cnt - 1)];
            return PAGE_W'($urandom_range(0, 15));
        end
        return PAGE_W'($urandom);
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (NPAGE + 8) @(posedge aclk);
    endtask

    // Receiver: random stalls, check each beat against the oldest expectation
    initial begin
        res_t exp_r, got;
        int g;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tdata[2:0]);
                got.page = m_tdata[14:3];
                got.last = m_tlast;
                n_results++;
                if (pending_res.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d page=%0h last=%0b",
                             $time, got.kind, got.page, got.last);
                    errors++;
                end else begin
                    exp_r = pending_res.pop_front();
                    if (got.kind == KIND_DEMOTED) n_demoted++;
                    if (got.kind == KIND_VICTIM) n_victims++;
                    if (got.kind == KIND_FULL) n_full++;
                    if (got.kind == KIND_EMPTY) n_empty++;
                    if (got.kind != exp_r.kind) begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, exp_r.kind, got.kind);
                        errors++;
                    end
                    if (got.page != exp_r.page) begin
                        $display("%0t: page expected %0h actual %0h",
                                 $time, exp_r.page, got.page);
                        errors++;
                    end
                    if (got.last != exp_r.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_r.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Directed table, then random traffic
    initial begin
        row_t rows[$];
        row_t r;
        int op;
        rows.push_back('{FUNC_EVICT,  12'hFFF, 1, KIND_EMPTY,  12'h000});
        rows.push_back('{FUNC_TICK,   12'h000, 1, KIND_OK,     12'h000});
        rows.push_back('{FUNC_ACCESS, 12'h123, 1, KIND_OK,     12'h000});
        rows.push_back('{FUNC_MAP,    12'h000, 1, KIND_OK,     12'h000});
        rows.push_back('{FUNC_MAP,    12'hFFF, 1, KIND_OK,     12'h000});
        rows.push_back('{FUNC_MAP,    12'hAAA, 1, KIND_OK,     12'h000});
        rows.push_back('{FUNC_MAP,    12'h555, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_MAP,    12'hFFF, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_ACCESS, 12'hFFF, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_ACCESS, 12'h777, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_TICK,   12'h000, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_TICK,   12'h000, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_ACCESS, 12'h555, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_ACCESS, 12'hAAA, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_TICK,   12'h000, 0, KIND_OK,     12'h000});
        rows.push_back('{FUNC_EVICT,  12'h000, 1, KIND_VICTIM, 12'h000});
        rows.push_back('{FUNC_EVICT,  12'h000, 0, KIND_OK,     12'h000});
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            r = rows[i];
            send_beat(r.func, r.page);
            if (r.fixed && (pending_res[$].kind != r.kind || pending_res[$].page != r.rpage)) begin
                $display("%0t: table row %0d expected kind=%0d page=%0h, model kind=%0d page=%0h",
                         $time, i, r.kind, r.rpage, pending_res[$].kind, pending_res[$].page);
                errors++;
            end
        end
        // Fill to capacity, check the full case, then mark the tail and head entries and tick
        while (lst_cnt < NPAGE) send_beat(FUNC_MAP, pick_page());
        send_beat(FUNC_MAP, 12'h0F0);
        send_beat(FUNC_ACCESS, lst_page[NPAGE-1]);
        send_beat(FUNC_ACCESS, lst_page[0]);
        send_beat(FUNC_TICK, '0);
        // Hold the sender until every result is back
        wait_drain();
        for (int n = 0; n < 330; n++) begin
            op = $urandom_range(0, 99);
            if (op < 30) send_beat(FUNC_MAP, pick_page());
            else if (op < 62) send_beat(FUNC_ACCESS, pick_page());
            else if (op < 78) send_beat(FUNC_TICK, PAGE_W'($urandom));
            else send_beat(FUNC_EVICT, PAGE_W'($urandom));
            if (n == 160) wait_drain();
        end
        wait_drain();
        $display("Covered %0d result beats: %0d demoted, %0d victims, %0d full, %0d empty.",
                 n_results, n_demoted, n_victims, n_full, n_empty);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
